FILE: rtl/frmtc_pkg.sv
// Shared types, rate codes and per-rate constants for the frame to timecode converter.
// No dependencies; every other file in this block imports this package.
package frmtc_pkg;

   localparam int FRAME_MAG_BITS_DEF = 24;

   // Configuration register codes.
   localparam logic [2:0] MODE_23976 = 3'd0;
   localparam logic [2:0] MODE_24    = 3'd1;
   localparam logic [2:0] MODE_25    = 3'd2;
   localparam logic [2:0] MODE_2997  = 3'd3;
   localparam logic [2:0] MODE_30    = 3'd4;

   typedef logic [1:0] rate_type;

   localparam rate_type RATE_24 = 2'd0;
   localparam rate_type RATE_25 = 2'd1;
   localparam rate_type RATE_30 = 2'd2;
   localparam rate_type RATE_DF = 2'd3;

   localparam logic [16:0] PER_HOUR_24 = 17'd86400;
   localparam logic [16:0] PER_HOUR_25 = 17'd90000;
   localparam logic [16:0] PER_HOUR_30 = 17'd108000;
   localparam logic [16:0] PER_HOUR_DF = 17'd107892;

   localparam int SEC_SHIFT = 16;
   localparam logic [11:0] SEC_RECIP_24 = 12'(((1 << SEC_SHIFT) + 23) / 24);
   localparam logic [11:0] SEC_RECIP_25 = 12'(((1 << SEC_SHIFT) + 24) / 25);
   localparam logic [11:0] SEC_RECIP_30 = 12'(((1 << SEC_SHIFT) + 29) / 30);

   typedef struct packed {
      logic        neg;
      rate_type    rate;
      logic [7:0]  hh;
      logic        ovf;
      logic [16:0] rest;
   } hour_type;

   typedef struct packed {
      logic        neg;
      rate_type    rate;
      logic [7:0]  hh;
      logic        ovf;
      logic [5:0]  mm;
      logic [10:0] rest;
   } minute_type;

   typedef struct packed {
      logic        neg;
      logic [7:0]  hh;
      logic [5:0]  mm;
      logic [5:0]  ss;
      logic [4:0]  ff;
      logic [31:0] bcd;
      logic        ovf;
   } result_type;

   function automatic rate_type decode_rate(logic [2:0] mode);
      rate_type r;
      case (mode)
         MODE_23976, MODE_24: r = RATE_24;
         MODE_2997:           r = RATE_DF;
         MODE_30:             r = RATE_30;
         default:             r = RATE_25;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] fps_of(rate_type r);
      logic [4:0] f;
      case (r)
         RATE_24: f = 5'd24;
         RATE_25: f = 5'd25;
         default: f = 5'd30;
      endcase
      return f;
   endfunction

   function automatic logic [16:0] per_hour(rate_type r);
      logic [16:0] v;
      case (r)
         RATE_24: v = PER_HOUR_24;
         RATE_25: v = PER_HOUR_25;
         RATE_30: v = PER_HOUR_30;
         default: v = PER_HOUR_DF;
      endcase
      return v;
   endfunction

   function automatic logic [14:0] per_ten(rate_type r);
      logic [14:0] v;
      case (r)
         RATE_24: v = 15'd14400;
         RATE_25: v = 15'd15000;
         RATE_30: v = 15'd18000;
         default: v = 15'd17982;
      endcase
      return v;
   endfunction

   // Length of the first minute of a ten-minute block.
   function automatic logic [10:0] per_min(rate_type r);
      logic [10:0] v;
      case (r)
         RATE_24: v = 11'd1440;
         RATE_25: v = 11'd1500;
         default: v = 11'd1800;
      endcase
      return v;
   endfunction

   // Length of the other nine minutes; drop-frame minutes lose two labels.
   function automatic logic [10:0] per_min_rest(rate_type r);
      logic [10:0] v;
      case (r)
         RATE_24: v = 11'd1440;
         RATE_25: v = 11'd1500;
         RATE_30: v = 11'd1800;
         default: v = 11'd1798;
      endcase
      return v;
   endfunction

   function automatic logic [11:0] sec_recip(rate_type r);
      logic [11:0] v;
      case (r)
         RATE_24: v = SEC_RECIP_24;
         RATE_25: v = SEC_RECIP_25;
         default: v = SEC_RECIP_30;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/frmtc_hour_div.sv
// Front of the pipeline: sign and magnitude, then the hour split by reciprocal multiply.
// Depends on frmtc_pkg. Four register stages.
module frmtc_hour_div #(
   parameter int FRAME_MAG_BITS = frmtc_pkg::FRAME_MAG_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [2:0]          rate_mode,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [24:0]         frame_count,
   output logic                out_valid,
   input  logic                out_ready,
   output frmtc_pkg::hour_type out_data
);
   import frmtc_pkg::*;

   localparam int B     = FRAME_MAG_BITS;
   localparam int RH_W  = B - 15;
   localparam int HH_W  = B - 15;
   localparam int P_W   = B + RH_W;
   localparam int QD_W  = HH_W + 17;
   localparam logic [31:0] MAG_MAX = 32'((64'(1) << B) - 64'(1));

   localparam logic [RH_W-1:0] RH_24 = RH_W'((64'(1) << B) / 64'(PER_HOUR_24));
   localparam logic [RH_W-1:0] RH_25 = RH_W'((64'(1) << B) / 64'(PER_HOUR_25));
   localparam logic [RH_W-1:0] RH_30 = RH_W'((64'(1) << B) / 64'(PER_HOUR_30));
   localparam logic [RH_W-1:0] RH_DF = RH_W'((64'(1) << B) / 64'(PER_HOUR_DF));

   logic            s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic            s1_ready, s2_ready, s3_ready, s4_ready;
   logic            s1_neg_ff, s2_neg_ff, s3_neg_ff;
   rate_type        s1_rate_ff, s2_rate_ff, s3_rate_ff;
   logic [B-1:0]    s1_mag_ff, s2_mag_ff, s3_mag_ff;
   logic [B-1:0]    s1_mag_in;
   logic [P_W-1:0]  s2_prod_ff, s2_prod_in;
   logic [RH_W-1:0] recip;
   logic [HH_W-1:0] s3_hq_ff, s3_hq_in;
   logic [B-1:0]    s3_hqd_ff, s3_hqd_in;
   hour_type        s4_data_ff, s4_data_in;
   logic [24:0]     mag25;
   logic [31:0]     mag32;
   logic [31:0]     rem32;
   logic            fix;
   logic [HH_W-1:0] hh_full;

   assign s4_ready = !s4_valid_ff || out_ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // Stage 1: magnitude, clipped to the configured magnitude width.
   always_comb begin
      mag25 = frame_count[24] ? (~frame_count + 25'd1) : frame_count;
      mag32 = 32'(mag25);
      s1_mag_in = (mag32 > MAG_MAX) ? MAG_MAX[B-1:0] : mag32[B-1:0];
   end

   // Stage 2: estimate of magnitude / frames-per-hour, low by at most one.
   always_comb begin
      case (s1_rate_ff)
         RATE_24: recip = RH_24;
         RATE_25: recip = RH_25;
         RATE_30: recip = RH_30;
         default: recip = RH_DF;
      endcase
      s2_prod_in = P_W'(s1_mag_ff) * P_W'(recip);
   end

   // Stage 3: back-multiply the estimate.
   always_comb begin
      s3_hq_in  = s2_prod_ff[P_W-1 -: HH_W];
      s3_hqd_in = B'(QD_W'(s3_hq_in) * QD_W'(per_hour(s2_rate_ff)));
   end

   // Stage 4: one correction step gives the exact hour and remainder.
   always_comb begin
      rem32   = 32'(s3_mag_ff - s3_hqd_ff);
      fix     = rem32 >= 32'(per_hour(s3_rate_ff));
      hh_full = s3_hq_ff + HH_W'(fix);
      s4_data_in.neg  = s3_neg_ff;
      s4_data_in.rate = s3_rate_ff;
      s4_data_in.hh   = 8'(hh_full);
      s4_data_in.ovf  = 32'(hh_full) > 32'd99;
      s4_data_in.rest = 17'(rem32 - (fix ? 32'(per_hour(s3_rate_ff)) : 32'd0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
         if (s4_ready) s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_neg_ff  <= frame_count[24];
         s1_rate_ff <= decode_rate(rate_mode);
         s1_mag_ff  <= s1_mag_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_neg_ff  <= s1_neg_ff;
         s2_rate_ff <= s1_rate_ff;
         s2_mag_ff  <= s1_mag_ff;
         s2_prod_ff <= s2_prod_in;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_neg_ff  <= s2_neg_ff;
         s3_rate_ff <= s2_rate_ff;
         s3_mag_ff  <= s2_mag_ff;
         s3_hq_ff   <= s3_hq_in;
         s3_hqd_ff  <= s3_hqd_in;
      end
      if (s4_ready && s3_valid_ff) begin
         s4_data_ff <= s4_data_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_data  = s4_data_ff;

endmodule

FILE: rtl/frmtc_min_split.sv
// Middle of the pipeline: ten-minute block and minute within it, with drop-frame lengths.
// Depends on frmtc_pkg. Four register stages.
module frmtc_min_split (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  frmtc_pkg::hour_type   in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output frmtc_pkg::minute_type out_data
);
   import frmtc_pkg::*;

   logic        s5_valid_ff, s6_valid_ff, s7_valid_ff, s8_valid_ff;
   logic        s5_ready, s6_ready, s7_ready, s8_ready;
   hour_type    s5_h_ff, s6_h_ff, s6_h_in, s7_h_ff;
   logic [2:0]  s5_tens_ff, s5_tens_in, s6_tens_ff, s7_tens_ff;
   logic [3:0]  s7_min_ff, s7_min_in;
   minute_type  s8_data_ff, s8_data_in;
   logic [14:0] bound;
   logic [14:0] base;
   logic [14:0] n3;
   logic        late_minute;

   assign s8_ready = !s8_valid_ff || out_ready;
   assign s7_ready = !s7_valid_ff || s8_ready;
   assign s6_ready = !s6_valid_ff || s7_ready;
   assign s5_ready = !s5_valid_ff || s6_ready;
   assign in_ready = s5_ready;

   // Stage 5: which ten-minute block, by compares against its starts.
   always_comb begin
      s5_tens_in = 3'd0;
      for (int k = 1; k <= 5; k++) begin
         if (in_data.rest >= 17'(17'(k) * 17'(per_ten(in_data.rate)))) begin
            s5_tens_in = 3'(k);
         end
      end
   end

   // Stage 6: offset within the ten-minute block.
   always_comb begin
      s6_h_in      = s5_h_ff;
      s6_h_in.rest = s5_h_ff.rest - 17'(s5_tens_ff) * 17'(per_ten(s5_h_ff.rate));
   end

   // Stage 7: minute within the block; with drop-frame, only the first minute keeps all labels.
   always_comb begin
      s7_min_in = 4'd0;
      for (int k = 1; k <= 9; k++) begin
         bound = 15'(per_min(s6_h_ff.rate))
               + 15'(k - 1) * 15'(per_min_rest(s6_h_ff.rate));
         if (s6_h_ff.rest[14:0] >= bound) begin
            s7_min_in = 4'(k);
         end
      end
   end

   // Stage 8: frame within the minute; a dropped minute starts at label two.
   always_comb begin
      base = (s7_min_ff == 4'd0) ? 15'd0
           : 15'(per_min(s7_h_ff.rate))
             + 15'(s7_min_ff - 4'd1) * 15'(per_min_rest(s7_h_ff.rate));
      n3          = s7_h_ff.rest[14:0] - base;
      late_minute = (s7_h_ff.rate == RATE_DF) && (s7_min_ff != 4'd0);
      s8_data_in.neg  = s7_h_ff.neg;
      s8_data_in.rate = s7_h_ff.rate;
      s8_data_in.hh   = s7_h_ff.hh;
      s8_data_in.ovf  = s7_h_ff.ovf;
      s8_data_in.mm   = 6'(s7_tens_ff) * 6'd10 + 6'(s7_min_ff);
      s8_data_in.rest = n3[10:0] + (late_minute ? 11'd2 : 11'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
      end else begin
         if (s5_ready) s5_valid_ff <= in_valid;
         if (s6_ready) s6_valid_ff <= s5_valid_ff;
         if (s7_ready) s7_valid_ff <= s6_valid_ff;
         if (s8_ready) s8_valid_ff <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s5_ready && in_valid) begin
         s5_h_ff    <= in_data;
         s5_tens_ff <= s5_tens_in;
      end
      if (s6_ready && s5_valid_ff) begin
         s6_h_ff    <= s6_h_in;
         s6_tens_ff <= s5_tens_ff;
      end
      if (s7_ready && s6_valid_ff) begin
         s7_h_ff    <= s6_h_ff;
         s7_tens_ff <= s6_tens_ff;
         s7_min_ff  <= s7_min_in;
      end
      if (s8_ready && s7_valid_ff) begin
         s8_data_ff <= s8_data_in;
      end
   end

   assign out_valid = s8_valid_ff;
   assign out_data  = s8_data_ff;

endmodule

FILE: rtl/frmtc_sec_split.sv
// Tail of the pipeline: seconds and frames by reciprocal multiply, then BCD packing.
// Depends on frmtc_pkg. Three register stages; the last is the output register.
module frmtc_sec_split (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  frmtc_pkg::minute_type in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output frmtc_pkg::result_type out_data
);
   import frmtc_pkg::*;

   logic        s9_valid_ff, s10_valid_ff, s11_valid_ff;
   logic        s9_ready, s10_ready, s11_ready;
   minute_type  s9_m_ff;
   logic [22:0] s9_prod_ff, s9_prod_in;
   result_type  s10_data_ff, s10_data_in;
   result_type  s11_data_ff, s11_data_in;
   logic [6:0]  hh_shown;

   // Two decimal digits of a value below one hundred.
   function automatic logic [7:0] bcd2(logic [6:0] v);
      logic [17:0] p;
      logic [3:0]  t;
      p = 18'(v) * 18'd205;
      t = p[14:11];
      return {t, 4'(v - 7'(t) * 7'd10)};
   endfunction

   assign s11_ready = !s11_valid_ff || out_ready;
   assign s10_ready = !s10_valid_ff || s11_ready;
   assign s9_ready  = !s9_valid_ff || s10_ready;
   assign in_ready  = s9_ready;

   // The rounded-up reciprocal is exact for every frame offset within a minute.
   assign s9_prod_in = 23'(in_data.rest) * 23'(sec_recip(in_data.rate));

   always_comb begin
      s10_data_in     = '0;
      s10_data_in.neg = s9_m_ff.neg;
      s10_data_in.hh  = s9_m_ff.hh;
      s10_data_in.ovf = s9_m_ff.ovf;
      s10_data_in.mm  = s9_m_ff.mm;
      s10_data_in.ss  = s9_prod_ff[SEC_SHIFT +: 6];
      s10_data_in.ff  = 5'(s9_m_ff.rest
                           - 11'(s10_data_in.ss) * 11'(fps_of(s9_m_ff.rate)));
   end

   always_comb begin
      hh_shown        = s10_data_ff.ovf ? 7'd99 : s10_data_ff.hh[6:0];
      s11_data_in     = s10_data_ff;
      s11_data_in.bcd = {bcd2(hh_shown), bcd2(7'(s10_data_ff.mm)),
                         bcd2(7'(s10_data_ff.ss)), bcd2(7'(s10_data_ff.ff))};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_valid_ff  <= 1'b0;
         s10_valid_ff <= 1'b0;
         s11_valid_ff <= 1'b0;
      end else begin
         if (s9_ready)  s9_valid_ff  <= in_valid;
         if (s10_ready) s10_valid_ff <= s9_valid_ff;
         if (s11_ready) s11_valid_ff <= s10_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s9_ready && in_valid) begin
         s9_m_ff    <= in_data;
         s9_prod_ff <= s9_prod_in;
      end
      if (s10_ready && s9_valid_ff) begin
         s10_data_ff <= s10_data_in;
      end
      if (s11_ready && s10_valid_ff) begin
         s11_data_ff <= s11_data_in;
      end
   end

   assign out_valid = s11_valid_ff;
   assign out_data  = s11_data_ff;

endmodule

FILE: rtl/frame_to_timecode_bcd.sv
// Top level of the frame count to timecode converter with packed BCD output.
// Depends on frmtc_pkg, frmtc_hour_div, frmtc_min_split and frmtc_sec_split.
//
// Converts the magnitude of a signed frame count into hours, minutes, seconds
// and frames at the rate held in the rate register, with drop-frame counting
// at 29.97, and returns the same time as an eight-digit BCD word plus sign and
// hour-overflow flags. The block is an eleven-stage pipeline with a valid bit
// and a per-stage ready in every stage: it takes one item per clock while the
// output side does not stall. A stall holds only the stages that are full, so
// bubbles close up behind a waiting result. The hour split is a reciprocal
// multiply, a back-multiply and a correction in separate stages. Write the
// rate register only when the pipeline is empty.
module frame_to_timecode_bcd #(
   parameter int FRAME_MAG_BITS = frmtc_pkg::FRAME_MAG_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_wdata,   // rate_mode
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // frame_count [24:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // hours [7:0], minutes [13:8], seconds [19:14],
                                    // frames [24:20], bcd_word [56:25]
   output logic [1:0]  rsp_tuser    // is_negative [0], hours_overflow [1]
);
   import frmtc_pkg::*;

   logic [2:0] rate_mode_ff, rate_mode_in;
   logic       hour_valid, hour_ready;
   hour_type   hour_data;
   logic       min_valid, min_ready;
   minute_type min_data;
   result_type res;

   assign rate_mode_in = csr_we ? csr_wdata : rate_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_mode_ff <= MODE_25;
      end else begin
         rate_mode_ff <= rate_mode_in;
      end
   end

   frmtc_hour_div #(
      .FRAME_MAG_BITS(FRAME_MAG_BITS)
   ) u_hour (
      .clock       (clock),
      .reset       (reset),
      .rate_mode   (rate_mode_ff),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .frame_count (req_tdata[24:0]),
      .out_valid   (hour_valid),
      .out_ready   (hour_ready),
      .out_data    (hour_data)
   );

   frmtc_min_split u_min (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (hour_valid),
      .in_ready  (hour_ready),
      .in_data   (hour_data),
      .out_valid (min_valid),
      .out_ready (min_ready),
      .out_data  (min_data)
   );

   frmtc_sec_split u_sec (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (min_valid),
      .in_ready  (min_ready),
      .in_data   (min_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (res)
   );

   assign rsp_tdata = {7'd0, res.bcd, res.ff, res.ss, res.mm, res.hh};
   assign rsp_tuser = {res.ovf, res.neg};

   // An overflowed hour count always shows as 99 in the BCD word.
   a_ovf_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && res.ovf |-> res.bcd[31:24] == 8'h99)
      else $error("BCD hours not saturated on overflow");

   // The split fields never leave their ranges.
   a_fields_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> res.mm < 6'd60 && res.ss < 6'd60 && res.ff < 5'd30)
      else $error("timecode field out of range");

   // The pipeline comes out of reset empty.
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

FILE: dv/frame_to_timecode_bcd_tb.sv
// Self-checking testbench for frame_to_timecode_bcd: a directed table and then random phases,
// each under one rate setting, are checked against typed rows or a timecode predictor in the bench.
// Depends on frmtc_pkg and the frame_to_timecode_bcd RTL.
`timescale 1ns / 100ps

module frame_to_timecode_bcd_tb;
   import frmtc_pkg::*;

   localparam int unsigned MAG_MAX = (1 << FRAME_MAG_BITS_DEF) - 1;
   localparam logic [2:0] MODE_SPARE_5 = 3'd5;
   localparam logic [2:0] MODE_SPARE_6 = 3'd6;
   localparam logic [2:0] MODE_SPARE_7 = 3'd7;
   localparam int PHASES = 12;
   localparam int PHASE_ITEMS = 88;
   localparam int HOLD_CYCLES = 80;
   localparam int HOLD_AT_ITEM = 300;
   localparam int DRAIN_CYCLES = 16;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic        neg;
      logic [7:0]  hh;
      logic [5:0]  mm;
      logic [5:0]  ss;
      logic [4:0]  ff;
      logic [31:0] bcd;
      logic        ovf;
   } timecode_type;

   typedef struct packed {
      logic [2:0]   mode;
      logic [24:0]  count;
      logic         typed;
      timecode_type tc;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   timecode_type pending_tc[$];
   stim_row_type stim_rows[$];
   logic [2:0]   rate_now;
   int           mismatches;
   int           items_sent;
   int           rx_wait;
   int           quiet;
   bit           hold_req;
   bit           tx_idle_on;
   bit           rx_idle_on;

   frame_to_timecode_bcd u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int unsigned frame_rate(logic [2:0] mode);
      int unsigned fps;
      case (mode)
         MODE_23976, MODE_24: fps = 24;
         MODE_2997, MODE_30:  fps = 30;
         default:             fps = 25;
      endcase
      return fps;
   endfunction

   function automatic logic [7:0] bcd_pair(int unsigned v);
      return {4'(v / 10), 4'(v % 10)};
   endfunction

   // Converts one frame count to its timecode under the given rate setting.
   function automatic timecode_type to_timecode(logic [24:0] fc, logic [2:0] mode);
      timecode_type r;
      logic [24:0]  mag;
      int unsigned  n, fps, hour_len, ten_len, min_len, hh, mm, ss, ff;
      bit           drop;
      fps = frame_rate(mode);
      drop = (mode == MODE_2997);
      mag = fc[24] ? (~fc + 25'd1) : fc;
      n = 32'(mag);
      if (n > MAG_MAX) n = MAG_MAX;
      hour_len = 3600 * fps - (drop ? 108 : 0);
      hh = n / hour_len;
      n = n % hour_len;
      ten_len = 600 * fps - (drop ? 18 : 0);
      mm = 10 * (n / ten_len);
      n = n % ten_len;
      min_len = 60 * fps;
      if (n >= min_len) begin
         mm = mm + 1;
         n = n - min_len;
         if (drop) min_len = min_len - 2;
         mm = mm + n / min_len;
         n = n % min_len;
      end
      // Minutes not divisible by ten start their first second at frame label 2.
      if (drop && (mm % 10) != 0) begin
         if (n < fps - 2) begin
            ss = 0;
            ff = n + 2;
         end else begin
            ss = 1 + (n - (fps - 2)) / fps;
            ff = (n - (fps - 2)) % fps;
         end
      end else begin
         ss = n / fps;
         ff = n % fps;
      end
      r.neg = fc[24];
      r.hh = 8'(hh);
      r.mm = 6'(mm);
      r.ss = 6'(ss);
      r.ff = 5'(ff);
      r.ovf = (hh > 99);
      r.bcd = {bcd_pair(r.ovf ? 99 : hh), bcd_pair(mm), bcd_pair(ss), bcd_pair(ff)};
      return r;
   endfunction

   // Random frame count: full-width noise, small values, minute boundaries and extremes.
   function automatic logic [24:0] pick_count(logic [2:0] mode);
      int unsigned fps, hour_len, ten_len, kind, m;
      int          val;
      bit          drop;
      fps = frame_rate(mode);
      drop = (mode == MODE_2997);
      hour_len = 3600 * fps - (drop ? 108 : 0);
      ten_len = 600 * fps - (drop ? 18 : 0);
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         return 25'($urandom);
      end else if (kind < 55) begin
         val = $urandom_range(0, 400000);
      end else if (kind < 90) begin
         m = $urandom_range(0, 59);
         val = $urandom_range(0, 3) * hour_len + (m / 10) * ten_len;
         if (m % 10 != 0) val = val + 60 * fps + (m % 10 - 1) * (60 * fps - (drop ? 2 : 0));
         val = val + $urandom_range(0, 40) - 3;
         if (val < 0) val = 0;
      end else begin
         case ($urandom_range(0, 4))
            0:       val = 0;
            1:       val = 1;
            2:       val = MAG_MAX;
            3:       val = 99 * hour_len + $urandom_range(0, 2 * hour_len);
            default: return 25'h1000000;
         endcase
      end
      if ($urandom_range(0, 1)) val = -val;
      return 25'(val);
   endfunction

   task automatic add_row(input logic [2:0] mode, input logic [24:0] count, input logic typed,
                          input timecode_type tc);
      stim_row_type row;
      row.mode = mode;
      row.count = count;
      row.typed = typed;
      row.tc = tc;
      stim_rows.push_back(row);
   endtask

   task automatic offer(input logic [24:0] fc, input logic typed, input timecode_type tc);
      int gap;
      gap = tx_idle_on ? $urandom_range(0, 7) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, fc};
      do @(posedge clock); while (!req_tready);
      pending_tc.push_back(typed ? tc : to_timecode(fc, rate_now));
      items_sent++;
      if (items_sent == HOLD_AT_ITEM) hold_req = 1'b1;
   endtask

   // The rate register is only written once every pending item has come out.
   task automatic set_rate(input logic [2:0] mode);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_tc.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= mode;
      @(negedge clock);
      csr_we <= 1'b0;
      rate_now = mode;
   endtask

   // Receiver ready: a random stall per item when enabled, or one long hold-off on request.
   always @(negedge clock) begin
      if (hold_req) begin
         hold_req = 1'b0;
         rx_wait = HOLD_CYCLES;
      end
      if (rx_wait > 0) begin
         rsp_tready <= 1'b0;
         rx_wait--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : check_blk
      timecode_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.neg = rsp_tuser[0];
         got.ovf = rsp_tuser[1];
         got.hh = rsp_tdata[7:0];
         got.mm = rsp_tdata[13:8];
         got.ss = rsp_tdata[19:14];
         got.ff = rsp_tdata[24:20];
         got.bcd = rsp_tdata[56:25];
         if (pending_tc.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual tdata %h tuser %b",
                     $time, rsp_tdata, rsp_tuser);
            mismatches++;
         end else begin
            want = pending_tc.pop_front();
            check_field("is_negative", want.neg, got.neg);
            check_field("hours", want.hh, got.hh);
            check_field("minutes", want.mm, got.mm);
            check_field("seconds", want.ss, got.ss);
            check_field("frames", want.ff, got.ff);
            check_field("bcd_word", want.bcd, got.bcd);
            check_field("hours_overflow", want.ovf, got.ovf);
         end
         rx_wait = rx_idle_on ? $urandom_range(0, 7) : 0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
         $display("frame_to_timecode_bcd regression: fail");
         $finish;
      end
   end

   initial begin : stimulus
      logic [2:0] mode;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = MODE_25;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      rate_now = MODE_25;
      mismatches = 0;
      items_sent = 0;
      rx_wait = 0;
      quiet = 0;
      hold_req = 1'b0;
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;

      // Rows stay in the reset rate first, then move through every rate code.
      add_row(MODE_25, 0, 1, '{1'b0, 8'd0, 6'd0, 6'd0, 5'd0, 32'h00000000, 1'b0});
      add_row(MODE_25, -1, 1, '{1'b1, 8'd0, 6'd0, 6'd0, 5'd1, 32'h00000001, 1'b0});
      add_row(MODE_25, 90000, 1, '{1'b0, 8'd1, 6'd0, 6'd0, 5'd0, 32'h01000000, 1'b0});
      add_row(MODE_23976, 16777215, 1,
              '{1'b0, 8'd194, 6'd10, 6'd50, 5'd15, 32'h99105015, 1'b1});
      // The most negative code saturates to the largest magnitude.
      add_row(MODE_23976, -16777216, 1,
              '{1'b1, 8'd194, 6'd10, 6'd50, 5'd15, 32'h99105015, 1'b1});
      add_row(MODE_23976, 8640000, 1, '{1'b0, 8'd100, 6'd0, 6'd0, 5'd0, 32'h99000000, 1'b1});
      add_row(MODE_24, 8553600, 1, '{1'b0, 8'd99, 6'd0, 6'd0, 5'd0, 32'h99000000, 1'b0});
      add_row(MODE_24, 8639999, 0, '0);
      add_row(MODE_24, -16777215, 0, '0);
      add_row(MODE_2997, 1799, 0, '0);
      add_row(MODE_2997, 1800, 1, '{1'b0, 8'd0, 6'd1, 6'd0, 5'd2, 32'h00010002, 1'b0});
      add_row(MODE_2997, 1827, 0, '0);
      add_row(MODE_2997, 1828, 0, '0);
      add_row(MODE_2997, 17981, 0, '0);
      add_row(MODE_2997, 17982, 1, '{1'b0, 8'd0, 6'd10, 6'd0, 5'd0, 32'h00100000, 1'b0});
      add_row(MODE_2997, 107891, 0, '0);
      add_row(MODE_2997, 107892, 1, '{1'b0, 8'd1, 6'd0, 6'd0, 5'd0, 32'h01000000, 1'b0});
      add_row(MODE_2997, 16777215, 0, '0);
      add_row(MODE_30, 107999, 0, '0);
      add_row(MODE_30, 108000, 1, '{1'b0, 8'd1, 6'd0, 6'd0, 5'd0, 32'h01000000, 1'b0});
      add_row(MODE_30, 16777215, 0, '0);
      add_row(MODE_SPARE_5, 1500, 0, '0);
      add_row(MODE_SPARE_6, -90000, 0, '0);
      add_row(MODE_SPARE_7, 16777215, 0, '0);

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         if (stim_rows[i].mode != rate_now) set_rate(stim_rows[i].mode);
         offer(stim_rows[i].count, stim_rows[i].typed, stim_rows[i].tc);
      end

      // The first eight phases walk every rate code in order; the rest pick one at random.
      for (int ph = 0; ph < PHASES; ph++) begin
         mode = (ph < 8) ? 3'(ph) : 3'($urandom_range(0, 7));
         set_rate(mode);
         tx_idle_on = (ph % 3 != 0);
         rx_idle_on = (ph % 3 == 1);
         repeat (PHASE_ITEMS) offer(pick_count(mode), 1'b0, '0);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_tc.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("frame_to_timecode_bcd regression: pass");
      end else begin
         $display("frame_to_timecode_bcd regression: fail");
      end
      $finish;
   end

endmodule
